/* rtl/core/bdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, command and status codes and the result record of the
// bounded deque core.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // fixed widths of the request and response fields
   localparam int CMD_WIDTH    = 3;
   localparam int DATA_WIDTH   = 32;
   localparam int INDEX_WIDTH  = 4;
   localparam int STATUS_WIDTH = 3;
   localparam int COUNT_WIDTH  = 5;

   localparam int REQ_TDATA_WIDTH = 40;
   localparam int REQ_TUSER_WIDTH = CMD_WIDTH;
   localparam int RSP_TDATA_WIDTH = 112;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_REMOVE     = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_REVERSE    = 3'd5,
      CMD_READ       = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_MISS  = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  read_value;
      logic [DATA_WIDTH-1:0]  back_value;
      logic [DATA_WIDTH-1:0]  front_value;
      logic                   is_empty;
      logic [COUNT_WIDTH-1:0] item_count;
      status_type             status;
   } result_type;

endpackage

/* rtl/core/bounded_deque_with_search_remove_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_remove_core
// Bounded deque of signed values with push/pop at both ends, remove by value,
// reverse, indexed read and clear; one response per request.
//
//   channel | dir | ports          | payload
//   req     | in  | req_t*         | tuser: cmd; tdata: item_value, read_index
//   rsp     | out | rsp_t*         | tdata: status, count, empty, front, back,
//           |     |                |        read_value
//
// Push, pop and clear run the command step, a front/back fetch when entries
// remain and the output step; remove and reverse add a walk over the entry
// store, one access at a time (search and shift, or pairwise swap).
// req_tready is high only while the sequencer is idle; a finished response
// sits in the output register while the next request is taken.
// Synchronous reset empties the deque; store contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_remove_core
   import bdq_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [31:0] item_value, [35:32] read_index, [39:36] zero
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [2:0] cmd
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [2:0] status, [7:3] item_count, [8] is_empty, [40:9] front_value,
   // [72:41] back_value, [104:73] read_value, [111:105] zero
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int PW = $clog2(CAPACITY);

   logic                   out_valid, out_ready;
   result_type             result;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;
   logic                   mem_wr_en;
   logic [PW-1:0]          mem_wr_addr, mem_rd_addr;
   logic [VALUE_WIDTH-1:0] mem_wr_data, mem_rd_data;

   bdq_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_cmd      (req_tuser[CMD_WIDTH-1:0]),
      .in_value    (req_tdata[DATA_WIDTH-1:0]),
      .in_index    (req_tdata[DATA_WIDTH+INDEX_WIDTH-1:DATA_WIDTH]),
      .out_valid   (out_valid),
      .out_ready   (out_ready),
      .out_result  (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bdq_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: load when empty or being drained
   assign out_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_valid && out_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff.read_value, rsp_data_ff.back_value,
                        rsp_data_ff.front_value, rsp_data_ff.is_empty,
                        rsp_data_ff.item_count, rsp_data_ff.status};

endmodule

/* rtl/core/bdq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_mem
// Entry store of the deque: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bdq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Command sequencer: walks the entry store one access at a time for search,
// shift, reverse and the final front/back fetch.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [CMD_WIDTH-1:0]        in_cmd,
   input  logic [DATA_WIDTH-1:0]       in_value,
   input  logic [INDEX_WIDTH-1:0]      in_index,
   output logic                        out_valid,
   input  logic                        out_ready,
   output result_type                  out_result,
   output logic                        mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
   output logic [VALUE_WIDTH-1:0]      mem_wr_data,
   output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
   input  logic [VALUE_WIDTH-1:0]      mem_rd_data
);

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [PW:0]   CAP_SUM  = (PW+1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
   localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REV_RDA,
      S_REV_RDB,
      S_REV_WRA,
      S_REV_WRB,
      S_READ_W,
      S_FIN_A,
      S_FIN_B,
      S_FIN_C,
      S_OUT
   } state_type;

   state_type             state_ff,  state_in;
   logic [PW-1:0]         front_ff,  front_in;
   logic [CW-1:0]         count_ff,  count_in;
   logic [CW-1:0]         i_ff,      i_in;
   cmd_type               cmd_ff,    cmd_in;
   logic [VALUE_WIDTH-1:0] val_ff,   val_in;
   logic [INDEX_WIDTH-1:0] idx_ff,   idx_in;
   status_type            status_ff, status_in;
   logic [VALUE_WIDTH-1:0] rd_ff,    rd_in;
   logic [VALUE_WIDTH-1:0] tmp_ff,   tmp_in;
   logic [VALUE_WIDTH-1:0] fv_ff,    fv_in;
   logic [VALUE_WIDTH-1:0] bv_ff,    bv_in;

   logic [CW-1:0]              cnt_m1, cnt_p1, half, j_pos, i_p1;
   logic [CW+INDEX_WIDTH-1:0]  idx_w, cnt_w;
   logic [VALUE_WIDTH+DATA_WIDTH-1:0] val_ext;
   logic [PW-1:0]              push_front_pos;
   logic                       full, empty;
   logic [CW+COUNT_WIDTH-1:0]  cnt_out;
   logic [VALUE_WIDTH+DATA_WIDTH-1:0] fv_out, bv_out, rd_out;

   // store slot of a position counted from the front
   function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                          input logic [PW-1:0] pos);
      logic [PW:0] s;
      s = {1'b0, base} + {1'b0, pos};
      if (s >= CAP_SUM) begin
         s = s - CAP_SUM;
      end
      return s[PW-1:0];
   endfunction

   assign cnt_m1  = count_ff - 1'b1;
   assign cnt_p1  = count_ff + 1'b1;
   assign half    = count_ff >> 1;
   assign j_pos   = cnt_m1 - i_ff;
   assign i_p1    = i_ff + 1'b1;
   assign idx_w   = {{CW{1'b0}}, idx_ff};
   assign cnt_w   = {{INDEX_WIDTH{1'b0}}, count_ff};
   assign val_ext = {{VALUE_WIDTH{in_value[DATA_WIDTH-1]}}, in_value};
   assign full    = (count_ff == CAP_CNT);
   assign empty   = (count_ff == '0);
   assign push_front_pos = (front_ff == '0) ? LAST_POS : front_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      i_in        = i_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      rd_in       = rd_ff;
      tmp_in      = tmp_ff;
      fv_in       = fv_ff;
      bv_in       = bv_ff;
      in_ready    = 1'b0;
      out_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = front_ff;
      mem_wr_data = val_ff;
      mem_rd_addr = front_ff;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd_in    = cmd_type'(in_cmd);
               val_in    = val_ext[VALUE_WIDTH-1:0];
               idx_in    = in_index;
               status_in = ST_OK;
               rd_in     = '0;
               i_in      = '0;
               state_in  = S_CMD;
            end
         end
         S_CMD: begin
            state_in = S_FIN_A;
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     front_in    = push_front_pos;
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = push_front_pos;
                     count_in    = cnt_p1;
                  end
               end
               CMD_PUSH_BACK: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot(front_ff, count_ff[PW-1:0]);
                     count_in    = cnt_p1;
                  end
               end
               CMD_REMOVE: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               CMD_POP_FRONT: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     front_in = slot(front_ff, PW'(1));
                     count_in = cnt_m1;
                  end
               end
               CMD_POP_BACK: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     count_in = cnt_m1;
                  end
               end
               CMD_REVERSE: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_REV_RDA;
                  end
               end
               CMD_READ: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else if (idx_w >= cnt_w) begin
                     status_in = ST_RANGE;
                  end else begin
                     mem_rd_addr = slot(front_ff, idx_w[PW-1:0]);
                     state_in    = S_READ_W;
                  end
               end
               CMD_CLEAR: begin
                  front_in = '0;
                  count_in = '0;
               end
               default: begin
                  state_in = S_FIN_A;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (i_ff == count_ff) begin
               status_in = ST_MISS;
               state_in  = S_FIN_A;
            end else begin
               mem_rd_addr = slot(front_ff, i_ff[PW-1:0]);
               state_in    = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (mem_rd_data == val_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               i_in     = i_p1;
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            // close the gap left by the match, one entry per pass
            if (i_p1 >= count_ff) begin
               count_in = cnt_m1;
               state_in = S_FIN_A;
            end else begin
               mem_rd_addr = slot(front_ff, i_p1[PW-1:0]);
               state_in    = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot(front_ff, i_ff[PW-1:0]);
            mem_wr_data = mem_rd_data;
            i_in        = i_p1;
            state_in    = S_SHIFT_RD;
         end
         S_REV_RDA: begin
            if (i_ff >= half) begin
               state_in = S_FIN_A;
            end else begin
               mem_rd_addr = slot(front_ff, i_ff[PW-1:0]);
               state_in    = S_REV_RDB;
            end
         end
         S_REV_RDB: begin
            tmp_in      = mem_rd_data;
            mem_rd_addr = slot(front_ff, j_pos[PW-1:0]);
            state_in    = S_REV_WRA;
         end
         S_REV_WRA: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot(front_ff, i_ff[PW-1:0]);
            mem_wr_data = mem_rd_data;
            state_in    = S_REV_WRB;
         end
         S_REV_WRB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot(front_ff, j_pos[PW-1:0]);
            mem_wr_data = tmp_ff;
            i_in        = i_p1;
            state_in    = S_REV_RDA;
         end
         S_READ_W: begin
            rd_in    = mem_rd_data;
            state_in = S_FIN_A;
         end
         S_FIN_A: begin
            if (empty) begin
               front_in = '0;
               fv_in    = '0;
               bv_in    = '0;
               state_in = S_OUT;
            end else begin
               mem_rd_addr = front_ff;
               state_in    = S_FIN_B;
            end
         end
         S_FIN_B: begin
            fv_in       = mem_rd_data;
            mem_rd_addr = slot(front_ff, cnt_m1[PW-1:0]);
            state_in    = S_FIN_C;
         end
         S_FIN_C: begin
            bv_in    = mem_rd_data;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register takes the result
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      i_ff      <= i_in;
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      tmp_ff    <= tmp_in;
      fv_ff     <= fv_in;
      bv_ff     <= bv_in;
   end

   assign cnt_out = {{COUNT_WIDTH{1'b0}}, count_ff};
   assign fv_out  = {{DATA_WIDTH{1'b0}}, fv_ff};
   assign bv_out  = {{DATA_WIDTH{1'b0}}, bv_ff};
   assign rd_out  = {{DATA_WIDTH{1'b0}}, rd_ff};

   always_comb begin
      out_result.status      = status_ff;
      out_result.item_count  = cnt_out[COUNT_WIDTH-1:0];
      out_result.is_empty    = empty;
      out_result.front_value = fv_out[DATA_WIDTH-1:0];
      out_result.back_value  = bv_out[DATA_WIDTH-1:0];
      out_result.read_value  = rd_out[DATA_WIDTH-1:0];
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque core. A tracker class keeps its
// own copy of the deque, predicts the response to every accepted request and
// compares each response field by field. Stimulus is a short directed list
// followed by random bursts that fill, drain, mix or are noise, under several idle and
// stall profiles and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import bdq_pkg::*;

   localparam int DEPTH         = CAPACITY_DEFAULT;
   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 60;

   // -------------------------------------------------------------------------
   // Tracker: deque copy plus the queue of responses still owed by the block
   // -------------------------------------------------------------------------
   class deque_tracker;
      logic [DATA_WIDTH-1:0] slots [DEPTH];
      int unsigned           head;
      int unsigned           held;
      result_type            pending_results [$];
      int unsigned           mismatches;

      function new();
         head       = 0;
         held       = 0;
         mismatches = 0;
      endfunction

      function int unsigned slot(int unsigned pos);
         return (head + pos) % DEPTH;
      endfunction

      function logic [DATA_WIDTH-1:0] held_value(int unsigned pos);
         return slots[slot(pos)];
      endfunction

      function void note_request(cmd_type op, logic [DATA_WIDTH-1:0] value,
                                 logic [INDEX_WIDTH-1:0] index);
         result_type            r;
         int unsigned           i;
         int unsigned           hit;
         logic [DATA_WIDTH-1:0] swap;
         r        = '0;
         r.status = ST_OK;
         case (op)
            CMD_PUSH_FRONT: begin
               if (held >= DEPTH) r.status = ST_FULL;
               else begin
                  head        = (head + DEPTH - 1) % DEPTH;
                  slots[head] = value;
                  held++;
               end
            end
            CMD_PUSH_BACK: begin
               if (held >= DEPTH) r.status = ST_FULL;
               else begin
                  slots[slot(held)] = value;
                  held++;
               end
            end
            CMD_REMOVE: begin
               if (held == 0) r.status = ST_EMPTY;
               else begin
                  hit = held;
                  for (i = 0; i < held; i++) begin
                     if (slots[slot(i)] == value) begin
                        hit = i;
                        break;
                     end
                  end
                  if (hit == held) r.status = ST_MISS;
                  else begin
                     // close the gap toward the front
                     for (i = hit; i + 1 < held; i++) slots[slot(i)] = slots[slot(i + 1)];
                     held--;
                  end
               end
            end
            CMD_POP_FRONT: begin
               if (held == 0) r.status = ST_EMPTY;
               else begin
                  head = slot(1);
                  held--;
               end
            end
            CMD_POP_BACK: begin
               if (held == 0) r.status = ST_EMPTY;
               else held--;
            end
            CMD_REVERSE: begin
               if (held == 0) r.status = ST_EMPTY;
               else begin
                  for (i = 0; i < held / 2; i++) begin
                     swap                     = slots[slot(i)];
                     slots[slot(i)]           = slots[slot(held - 1 - i)];
                     slots[slot(held - 1 - i)] = swap;
                  end
               end
            end
            CMD_READ: begin
               if (held == 0) r.status = ST_EMPTY;
               else if (index >= held) r.status = ST_RANGE;
               else r.read_value = slots[slot(index)];
            end
            default: begin
               head = 0;
               held = 0;
            end
         endcase
         if (held == 0) head = 0;
         r.item_count = COUNT_WIDTH'(held);
         r.is_empty   = (held == 0);
         if (held != 0) begin
            r.front_value = slots[slot(0)];
            r.back_value  = slots[slot(held - 1)];
         end
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                  logic [DATA_WIDTH-1:0] got);
         if (want !== got) begin
            mismatches++;
            $error("%s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_TDATA_WIDTH-1:0] data);
         result_type want;
         result_type got;
         got = result_type'(data[$bits(result_type)-1:0]);
         if (pending_results.size() == 0) begin
            mismatches++;
            $error("response: none expected, got %h", data);
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(got.status));
         compare_field("item_count", DATA_WIDTH'(want.item_count),
                       DATA_WIDTH'(got.item_count));
         compare_field("is_empty", DATA_WIDTH'(want.is_empty), DATA_WIDTH'(got.is_empty));
         compare_field("front_value", want.front_value, got.front_value);
         compare_field("back_value", want.back_value, got.back_value);
         compare_field("read_value", want.read_value, got.read_value);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [REQ_TUSER_WIDTH-1:0] req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   deque_tracker board = new();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_request   = 1'b0;
   int unsigned hold_left      = 0;
   int unsigned quiet_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_deque_with_search_remove_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // -------------------------------------------------------------------------
   // Response side: random stalls, long hold-off on demand, checking
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   task automatic send_request(input cmd_type op, input logic [DATA_WIDTH-1:0] value,
                               input logic [INDEX_WIDTH-1:0] index);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_WIDTH - DATA_WIDTH - INDEX_WIDTH){1'b0}}, index, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, value, index);
   endtask

   function automatic logic [DATA_WIDTH-1:0] random_value();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 3) return DATA_WIDTH'($urandom_range(4) - 2);
      if (roll == 3) begin
         case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // mode 0 fills, mode 1 drains, mode 2 mixes, mode 3 is noise
   function automatic cmd_type choose_cmd(int unsigned mode);
      int unsigned roll;
      roll = $urandom_range(99);
      case (mode)
         0: begin
            if (roll < 35) return CMD_PUSH_FRONT;
            if (roll < 72) return CMD_PUSH_BACK;
            if (roll < 82) return CMD_READ;
            if (roll < 92) return CMD_REMOVE;
            return CMD_REVERSE;
         end
         1: begin
            if (roll < 20) return CMD_POP_FRONT;
            if (roll < 40) return CMD_POP_BACK;
            if (roll < 65) return CMD_REMOVE;
            if (roll < 80) return CMD_READ;
            if (roll < 88) return CMD_REVERSE;
            if (roll < 97) return CMD_PUSH_BACK;
            return CMD_CLEAR;
         end
         2: begin
            // keep clear rare so the deque stays populated
            if (roll < 2) return CMD_CLEAR;
            return cmd_type'($urandom_range(6));
         end
         default: return cmd_type'($urandom_range(7));
      endcase
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned           sent;
      int unsigned           burst;
      int unsigned           mode;
      cmd_type               op;
      logic [DATA_WIDTH-1:0] value;
      logic [INDEX_WIDTH-1:0] index;
      sent = 0;
      while (sent < count) begin
         mode  = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
         burst = $urandom_range(40, 4);
         for (int unsigned k = 0; k < burst && sent < count; k++) begin
            op    = choose_cmd(mode);
            value = random_value();
            index = $urandom_range(15);
            // aim removes at held values most of the time
            if (op == CMD_REMOVE && board.held != 0 && $urandom_range(9) < 7)
               value = board.held_value($urandom_range(board.held - 1));
            if (op == CMD_READ && board.held != 0 && $urandom_range(9) < 7)
               index = $urandom_range(board.held - 1);
            send_request(op, value, index);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty deque: every command that needs entries
      send_request(CMD_POP_FRONT, 32'h0000_0001, 4'd0);
      send_request(CMD_POP_BACK, 32'h0000_0002, 4'd0);
      send_request(CMD_REMOVE, 32'h0000_0000, 4'd0);
      send_request(CMD_REVERSE, 32'hFFFF_FFFF, 4'd15);
      send_request(CMD_READ, 32'h0000_0000, 4'd0);
      send_request(CMD_CLEAR, 32'h0000_0000, 4'd0);
      // extremes at both ends, with a duplicate
      send_request(CMD_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
      send_request(CMD_PUSH_FRONT, 32'h8000_0000, 4'd15);
      send_request(CMD_PUSH_BACK, 32'h0000_0000, 4'd0);
      send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
      send_request(CMD_PUSH_BACK, 32'h8000_0000, 4'd0);
      send_request(CMD_READ, 32'h0000_0000, 4'd0);
      send_request(CMD_READ, 32'h0000_0000, 4'd4);
      send_request(CMD_READ, 32'h0000_0000, 4'd15);
      send_request(CMD_REMOVE, 32'h1234_5678, 4'd0);
      send_request(CMD_REMOVE, 32'h8000_0000, 4'd0);
      send_request(CMD_REVERSE, 32'h0000_0000, 4'd0);
      send_request(CMD_READ, 32'h0000_0000, 4'd2);
      send_request(CMD_POP_FRONT, 32'h0000_0000, 4'd0);
      send_request(CMD_POP_BACK, 32'h0000_0000, 4'd0);
      send_request(CMD_POP_BACK, 32'h0000_0000, 4'd0);
      send_request(CMD_REVERSE, 32'h0000_0000, 4'd0);
      send_request(CMD_CLEAR, 32'hFFFF_FFFF, 4'd15);
      send_request(CMD_PUSH_FRONT, 32'h0000_0001, 4'd0);

      send_idle_pct = 0;  recv_stall_pct = 0;  run_random(340);
      send_idle_pct = 72; recv_stall_pct = 0;  run_random(340);
      send_idle_pct = 0;  recv_stall_pct = 72; run_random(340);
      send_idle_pct = 26; recv_stall_pct = 26; run_random(340);

      // hold responses back while requests keep coming
      send_idle_pct = 0;  recv_stall_pct = 0;
      hold_request = 1'b1;
      run_random(60);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/bdq_pkg.sv
rtl/core/bdq_mem.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_deque_with_search_remove_core.sv
tb/sv/testbench.sv
